[hw/rtl/radar_measurement_jacobian_defines.svh]
// Assertion macros shared by the radar measurement Jacobian RTL.
`ifndef RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH

// Same-cycle implication, sampled on aclk and silent during reset.
`define RMJ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and silent during reset.
`define RMJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rmj_pkg.sv]
// Package with constants and types of the radar measurement Jacobian.
package rmj_pkg;

    localparam int          RMJ_FRAC_BITS  = 16;
    localparam logic [31:0] RMJ_THR_RESET  = 32'd7;
    localparam int          RMJ_SQRT_STEPS = 32;
    localparam int          RMJ_QUOT_W     = 33;
    localparam int          RMJ_DIV_LAT    = RMJ_QUOT_W + 2;
    localparam logic [63:0] RMJ_POS_LIMIT  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] RMJ_NEG_LIMIT  = 64'h0000_0000_8000_0000;
    localparam logic [31:0] RMJ_POS_SAT    = 32'h7FFF_FFFF;
    localparam logic [31:0] RMJ_NEG_SAT    = 32'h8000_0000;

    // Operands of one state vector as they travel down the front end.
    typedef struct packed {
        logic        pxneg;
        logic        pyneg;
        logic        dneg;
        logic        tc;
        logic [31:0] mpx;
        logic [31:0] mpy;
        logic [63:0] mdiff;
        logic [63:0] c;
        logic [95:0] prodx;
        logic [95:0] prody;
        logic [31:0] r;
        logic [95:0] cr;
    } rmj_job_t;

endpackage

[hw/rtl/rmj_div.sv]
// Pipelined restoring divider with a 32-bit signed saturating result.
module rmj_div import rmj_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = RMJ_QUOT_W
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic          neg,
    input  logic          zero,
    output logic [31:0]   res
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg [0:QW];
    logic [DW-1:0] rem_next [0:QW];
    logic [QW-1:0] nlo_reg [0:QW];
    logic [QW-1:0] nlo_next [0:QW];
    logic [QW-1:0] q_reg [0:QW];
    logic [QW-1:0] q_next [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [DW-1:0] den_next [0:QW];
    logic [QW:0]   ovf_reg, ovf_next;
    logic [QW:0]   neg_reg, neg_next;
    logic [QW:0]   zero_reg, zero_next;
    logic [31:0]   res_reg, res_next;

    // Stage 0 checks whether the quotient reaches 2^QW; later stages each
    // settle one quotient bit.
    always_comb begin
        logic [DW:0] t;
        logic        ge;
        rem_next[0]  = DW'(num[NW-1:QW]);
        nlo_next[0]  = num[QW-1:0];
        q_next[0]    = '0;
        den_next[0]  = den;
        ovf_next[0]  = CW'(num[NW-1:QW]) >= CW'(den);
        neg_next[0]  = neg;
        zero_next[0] = zero;
        for (int k = 1; k <= QW; k++) begin
            t            = {rem_reg[k-1], nlo_reg[k-1][QW-1]};
            ge           = t >= {1'b0, den_reg[k-1]};
            rem_next[k]  = ge ? DW'(t - {1'b0, den_reg[k-1]}) : DW'(t);
            nlo_next[k]  = nlo_reg[k-1] << 1;
            q_next[k]    = {q_reg[k-1][QW-2:0], ge};
            den_next[k]  = den_reg[k-1];
            ovf_next[k]  = ovf_reg[k-1];
            neg_next[k]  = neg_reg[k-1];
            zero_next[k] = zero_reg[k-1];
        end
    end

    always_comb begin
        if (zero_reg[QW]) begin
            res_next = '0;
        end else if (neg_reg[QW]) begin
            if (ovf_reg[QW] || (q_reg[QW] > QW'(RMJ_NEG_LIMIT))) begin
                res_next = RMJ_NEG_SAT;
            end else begin
                res_next = 32'(32'd0 - q_reg[QW][31:0]);
            end
        end else begin
            if (ovf_reg[QW] || (q_reg[QW] > QW'(RMJ_POS_LIMIT))) begin
                res_next = RMJ_POS_SAT;
            end else begin
                res_next = q_reg[QW][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QW; k++) begin
                rem_reg[k] <= rem_next[k];
                nlo_reg[k] <= nlo_next[k];
                q_reg[k]   <= q_next[k];
                den_reg[k] <= den_next[k];
            end
            ovf_reg  <= ovf_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[hw/rtl/rmj_front.sv]
// Front end: magnitudes, squared range, cross term, square root and r cubed.
module rmj_front import rmj_pkg::*; #(
    parameter int FRAC_BITS = RMJ_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic [31:0]        thr,
    output rmj_job_t           job,
    output logic               job_valid
);

    localparam int NS = RMJ_SQRT_STEPS;
    localparam int NV = NS + 7;

    logic [NV-1:0] v_reg;
    logic          ld_a;

    logic signed [31:0] a_px_reg, a_py_reg, a_vx_reg, a_vy_reg;

    logic [31:0]        b_mpx_next, b_mpy_next, b_mpx_reg, b_mpy_reg;
    logic [63:0]        b_sqx_next, b_sqy_next, b_sqx_reg, b_sqy_reg;
    logic signed [63:0] b_a_next, b_b_next, b_a_reg, b_b_reg;
    logic               b_pxneg_reg, b_pyneg_reg;

    rmj_job_t    c_job_next, c_job_reg;
    rmj_job_t    d_job_reg;
    logic [63:0] d_xlo_next, d_xhi_next, d_ylo_next, d_yhi_next;
    logic [63:0] d_xlo_reg, d_xhi_reg, d_ylo_reg, d_yhi_reg;
    rmj_job_t    e_job_next;

    rmj_job_t    sq_job_reg [0:NS];
    rmj_job_t    sq_job_next [0:NS];
    logic [63:0] sq_x_reg [0:NS];
    logic [63:0] sq_x_next [0:NS];
    logic [63:0] sq_r_reg [0:NS];
    logic [63:0] sq_r_next [0:NS];

    rmj_job_t    f_job_next, f_job_reg;
    logic [63:0] f_lo_next, f_hi_next, f_lo_reg, f_hi_reg;
    rmj_job_t    g_job_next, g_job_reg;

    // The entry stage may fill while the rest of the pipeline is held.
    assign ld_a    = en || !v_reg[0];
    assign s_ready = ld_a;

    assign b_mpx_next = a_px_reg[31] ? 32'(-a_px_reg) : 32'(a_px_reg);
    assign b_mpy_next = a_py_reg[31] ? 32'(-a_py_reg) : 32'(a_py_reg);
    assign b_sqx_next = b_mpx_next * b_mpx_next;
    assign b_sqy_next = b_mpy_next * b_mpy_next;
    assign b_a_next   = a_vx_reg * a_py_reg;
    assign b_b_next   = a_vy_reg * a_px_reg;

    always_comb begin
        c_job_next       = '0;
        c_job_next.pxneg = b_pxneg_reg;
        c_job_next.pyneg = b_pyneg_reg;
        c_job_next.mpx   = b_mpx_reg;
        c_job_next.mpy   = b_mpy_reg;
        c_job_next.c     = b_sqx_reg + b_sqy_reg;
        c_job_next.tc    = (c_job_next.c == 64'd0) ||
                           (c_job_next.c < (64'(thr) << FRAC_BITS));
        if (b_a_reg >= b_b_reg) begin
            c_job_next.mdiff = 64'(b_a_reg - b_b_reg);
            c_job_next.dneg  = 1'b0;
        end else begin
            c_job_next.mdiff = 64'(b_b_reg - b_a_reg);
            c_job_next.dneg  = 1'b1;
        end
    end

    assign d_xlo_next = c_job_reg.mpx * c_job_reg.mdiff[31:0];
    assign d_xhi_next = c_job_reg.mpx * c_job_reg.mdiff[63:32];
    assign d_ylo_next = c_job_reg.mpy * c_job_reg.mdiff[31:0];
    assign d_yhi_next = c_job_reg.mpy * c_job_reg.mdiff[63:32];

    always_comb begin
        e_job_next       = d_job_reg;
        e_job_next.prodx = 96'(d_xlo_reg) + {d_xhi_reg, 32'd0};
        e_job_next.prody = 96'(d_ylo_reg) + {d_yhi_reg, 32'd0};
    end

    // One result bit of the integer square root per stage.
    always_comb begin
        logic [63:0] bitv;
        logic [63:0] trial;
        sq_job_next[0] = e_job_next;
        sq_x_next[0]   = e_job_next.c;
        sq_r_next[0]   = '0;
        for (int i = 1; i <= NS; i++) begin
            bitv           = 64'd1 << (2 * (NS - i));
            trial          = sq_r_reg[i-1] + bitv;
            sq_job_next[i] = sq_job_reg[i-1];
            if (sq_x_reg[i-1] >= trial) begin
                sq_x_next[i] = sq_x_reg[i-1] - trial;
                sq_r_next[i] = (sq_r_reg[i-1] >> 1) + bitv;
            end else begin
                sq_x_next[i] = sq_x_reg[i-1];
                sq_r_next[i] = sq_r_reg[i-1] >> 1;
            end
        end
    end

    always_comb begin
        f_job_next   = sq_job_reg[NS];
        f_job_next.r = sq_r_reg[NS][31:0];
    end
    assign f_lo_next = f_job_next.c[31:0] * f_job_next.r;
    assign f_hi_next = f_job_next.c[63:32] * f_job_next.r;

    always_comb begin
        g_job_next    = f_job_reg;
        g_job_next.cr = 96'(f_lo_reg) + {f_hi_reg, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld_a) begin
                v_reg[0] <= s_valid;
            end
            if (en) begin
                v_reg[NV-1:1] <= v_reg[NV-2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_a) begin
            a_px_reg <= s_pos_x;
            a_py_reg <= s_pos_y;
            a_vx_reg <= s_vel_x;
            a_vy_reg <= s_vel_y;
        end
        if (en) begin
            b_mpx_reg   <= b_mpx_next;
            b_mpy_reg   <= b_mpy_next;
            b_sqx_reg   <= b_sqx_next;
            b_sqy_reg   <= b_sqy_next;
            b_a_reg     <= b_a_next;
            b_b_reg     <= b_b_next;
            b_pxneg_reg <= a_px_reg[31];
            b_pyneg_reg <= a_py_reg[31];
            c_job_reg   <= c_job_next;
            d_job_reg   <= c_job_reg;
            d_xlo_reg   <= d_xlo_next;
            d_xhi_reg   <= d_xhi_next;
            d_ylo_reg   <= d_ylo_next;
            d_yhi_reg   <= d_yhi_next;
            for (int i = 0; i <= NS; i++) begin
                sq_job_reg[i] <= sq_job_next[i];
                sq_x_reg[i]   <= sq_x_next[i];
                sq_r_reg[i]   <= sq_r_next[i];
            end
            f_job_reg <= f_job_next;
            f_lo_reg  <= f_lo_next;
            f_hi_reg  <= f_hi_next;
            g_job_reg <= g_job_next;
        end
    end

    assign job       = g_job_reg;
    assign job_valid = v_reg[NV-1];

endmodule

[hw/rtl/radar_measurement_jacobian.sv]
// Top level of the radar measurement Jacobian pipeline.
// Throughput: one request per cycle while the m_ port is not stalled; 39
// front-end stages (32 of them the square root) are followed by 35 stages of the six parallel dividers.
// Reset clears all valid bits and loads the range threshold with 7.
`include "radar_measurement_jacobian_defines.svh"

module radar_measurement_jacobian import rmj_pkg::*; #(
    parameter int FRAC_BITS = RMJ_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_range_dx,
    output logic signed [31:0] m_range_dy,
    output logic signed [31:0] m_bearing_dx,
    output logic signed [31:0] m_bearing_dy,
    output logic signed [31:0] m_rate_dx,
    output logic signed [31:0] m_rate_dy,
    output logic               m_too_close
);

    // Numerator widths: the range partials carry one fraction shift, the
    // bearing partials two, and the range-rate products one.
    localparam int N0W = 32 + FRAC_BITS;
    localparam int N2W = 32 + 2 * FRAC_BITS;
    localparam int N4W = 96 + FRAC_BITS;
    localparam int DL  = RMJ_DIV_LAT;

    logic [31:0]   thr_reg;
    logic          en;
    rmj_job_t      job;
    logic          job_valid;
    logic [DL-1:0] dv_reg;
    logic [DL-1:0] dtc_reg;
    logic [31:0]   res0, res1, res2, res3, res4, res5;

    // The whole pipeline advances together whenever the output register is
    // empty or its request is being taken; the entry stage can still fill
    // while the rest is held.
    assign en = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= RMJ_THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    rmj_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pos_x   (s_pos_x),
        .s_pos_y   (s_pos_y),
        .s_vel_x   (s_vel_x),
        .s_vel_y   (s_vel_y),
        .thr       (thr_reg),
        .job       (job),
        .job_valid (job_valid)
    );

    // Range partials: magnitude over r.
    rmj_div #(.NW(N0W), .DW(32)) u_div_rx (
        .aclk (aclk), .en (en),
        .num  (N0W'(job.mpx) << FRAC_BITS), .den (job.r),
        .neg  (job.pxneg), .zero (job.tc), .res (res0)
    );
    rmj_div #(.NW(N0W), .DW(32)) u_div_ry (
        .aclk (aclk), .en (en),
        .num  (N0W'(job.mpy) << FRAC_BITS), .den (job.r),
        .neg  (job.pyneg), .zero (job.tc), .res (res1)
    );

    // Bearing partials: magnitude over r squared; the x partial is negated,
    // so it is negative for a strictly positive y.
    rmj_div #(.NW(N2W), .DW(64)) u_div_bx (
        .aclk (aclk), .en (en),
        .num  (N2W'(job.mpy) << (2 * FRAC_BITS)), .den (job.c),
        .neg  (!job.pyneg && (job.mpy != 32'd0)), .zero (job.tc), .res (res2)
    );
    rmj_div #(.NW(N2W), .DW(64)) u_div_by (
        .aclk (aclk), .en (en),
        .num  (N2W'(job.mpx) << (2 * FRAC_BITS)), .den (job.c),
        .neg  (job.pxneg), .zero (job.tc), .res (res3)
    );

    // Range-rate position partials: product with the cross term over r cubed.
    rmj_div #(.NW(N4W), .DW(96)) u_div_qx (
        .aclk (aclk), .en (en),
        .num  (N4W'(job.prody) << FRAC_BITS), .den (job.cr),
        .neg  (job.pyneg != job.dneg), .zero (job.tc), .res (res4)
    );
    rmj_div #(.NW(N4W), .DW(96)) u_div_qy (
        .aclk (aclk), .en (en),
        .num  (N4W'(job.prodx) << FRAC_BITS), .den (job.cr),
        .neg  (job.pxneg == job.dneg), .zero (job.tc), .res (res5)
    );

    // Valid and too-close flags follow the divider stages in step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg  <= '0;
            dtc_reg <= '0;
        end else if (en) begin
            dv_reg  <= {dv_reg[DL-2:0], job_valid};
            dtc_reg <= {dtc_reg[DL-2:0], job_valid && job.tc};
        end
    end

    assign m_valid      = dv_reg[DL-1];
    assign m_too_close  = dtc_reg[DL-1];
    assign m_range_dx   = res0;
    assign m_range_dy   = res1;
    assign m_bearing_dx = res2;
    assign m_bearing_dy = res3;
    assign m_rate_dx    = res4;
    assign m_rate_dy    = res5;

    `RMJ_ASSERT_NOW(a_tc_zero, m_too_close, (m_range_dx == 0) && (m_bearing_dy == 0) && (m_rate_dx == 0) && (m_rate_dy == 0), "too_close result has nonzero entries")
    `RMJ_ASSERT_NOW(a_tc_valid, m_too_close, m_valid, "too_close raised without a result")
    `RMJ_ASSERT_NOW(a_stall_only, !s_ready, m_valid && !m_ready, "input refused without an output stall")
    `RMJ_ASSERT_NEXT(a_stall_hold, !s_ready, m_valid, "held result vanished")

endmodule
